@@ design/gcf_pkg.sv @@
// Shared types, codes and the command port decode for the geometry command queue.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package gcf_pkg;

  // Default storage sizes.
  localparam int FIFO_DEPTH_DEF = 256;
  localparam int PIPE_DEPTH_DEF = 4;

  // The pipe is refilled from the FIFO when it drops below this many entries.
  localparam int REFILL_BELOW = 3;

  // Field widths fixed by the interface.
  localparam int CMD_W  = 7;
  localparam int DATA_W = 32;
  localparam int PORT_W = 12;

  // Interrupt modes.
  localparam logic [1:0] IRQ_NEVER      = 2'd0;
  localparam logic [1:0] IRQ_BELOW_HALF = 2'd1;
  localparam logic [1:0] IRQ_EMPTY      = 2'd2;
  localparam logic [1:0] IRQ_RESERVED   = 2'd3;

  // Error codes.
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNKNOWN    = 2'd1;
  localparam logic [1:0] ERR_FIFO_FULL  = 2'd2;
  localparam logic [1:0] ERR_PIPE_EMPTY = 2'd3;

  // Request kinds.
  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_DEQUEUE = 1'b1;

  // One queued command: command code over data word.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] data;
  } entry_t;

  // Pipe control from the sequencer.
  typedef struct packed {
    logic push;
    logic pop;
  } pipe_ctl_t;

  // Result of the port decode.
  typedef struct packed {
    logic             hit;
    logic [CMD_W-1:0] cmd;
  } decode_t;

  // Maps a command port offset to its command code.
  function automatic decode_t gcf_decode(input logic [PORT_W-1:0] port);
    decode_t d;
    d.hit = 1'b1;
    case (port)
      12'h440: d.cmd = 7'h10;
      12'h444: d.cmd = 7'h11;
      12'h448: d.cmd = 7'h12;
      12'h454: d.cmd = 7'h15;
      12'h460: d.cmd = 7'h18;
      12'h464: d.cmd = 7'h19;
      12'h468: d.cmd = 7'h1A;
      12'h470: d.cmd = 7'h1C;
      12'h480: d.cmd = 7'h20;
      12'h48C: d.cmd = 7'h23;
      12'h4A4: d.cmd = 7'h29;
      12'h4A8: d.cmd = 7'h2A;
      12'h500: d.cmd = 7'h40;
      12'h504: d.cmd = 7'h41;
      12'h540: d.cmd = 7'h50;
      12'h580: d.cmd = 7'h60;
      default: begin
        d.hit = 1'b0;
        d.cmd = '0;
      end
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

@@ design/gcf_fifo_mem.sv @@
// Main FIFO storage: one write port and one read port with registered read data.
// Depends on gcf_pkg for the entry type.
`default_nettype none

module gcf_fifo_mem #(
  parameter int DEPTH = gcf_pkg::FIFO_DEPTH_DEF
) (
  input  wire                          clk,
  input  wire                          wr_en,
  input  wire  [$clog2(DEPTH)-1:0]     wr_addr,
  input  gcf_pkg::entry_t              wr_data,
  input  wire  [$clog2(DEPTH)-1:0]     rd_addr,
  output gcf_pkg::entry_t              rd_data
);
  import gcf_pkg::*;

  entry_t mem_r [DEPTH];
  entry_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ design/gcf_pipe.sv @@
// Short pipe of entries in front of the engine: push at the back, pop shifts down.
// Depends on gcf_pkg for the entry and control types.
`default_nettype none

module gcf_pipe #(
  parameter int PIPE_DEPTH = gcf_pkg::PIPE_DEPTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  gcf_pkg::pipe_ctl_t                ctl,
  input  gcf_pkg::entry_t                   push_entry,
  output gcf_pkg::entry_t                   front,
  output logic [$clog2(PIPE_DEPTH+1)-1:0]   count
);
  import gcf_pkg::*;

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  entry_t             pipe_r [PIPE_DEPTH];
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;

  // Pop shifts every entry one place forward; push fills the first free place.
  always_ff @(posedge clk) begin
    for (int k = 0; k < PIPE_DEPTH; k++) begin
      if (ctl.pop && (k < PIPE_DEPTH - 1)) begin
        pipe_r[k] <= pipe_r[(k + 1) % PIPE_DEPTH];
      end else if (ctl.push && (count_r == CNT_W'(k))) begin
        pipe_r[k] <= push_entry;
      end
    end
  end

  // Fill count.
  always_comb begin
    count_nxt = count_r;
    if (ctl.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign front = pipe_r[0];
  assign count = count_r;

endmodule

`default_nettype wire

@@ design/geometry_command_fifo_pipe.sv @@
// Top level of the geometry command queue: sequencer, FIFO pointers and result register.
// Depends on gcf_pkg, gcf_fifo_mem and gcf_pipe.
//
//   Channel   Handshake             Payload
//   --------  --------------------  -------------------------------------------------
//   input     start && !busy        in_req_type, in_port_offset, in_cmd_data
//   result    out_strobe (1 cycle)  out_entry_valid .. out_error_code
//   config    cfg_wr_en             cfg_wr_data (irq_mode)
//
// A write, a rejected request, or a dequeue that needs no refill completes in ST_IDLE.
// A refilling dequeue goes on to ST_MOVE1 and, if the FIFO holds more and the pipe has
// room, ST_MOVE2; each moves one FIFO entry through the memory's single read port.
// The result beat appears on the cycle after the last cycle of its request.
// Reset is synchronous, active low, and empties both queues; the memory is not cleared.
// The receiver cannot stall; busy holds off new requests during a refill.
`default_nettype none

module geometry_command_fifo_pipe #(
  parameter int FIFO_DEPTH = gcf_pkg::FIFO_DEPTH_DEF,
  parameter int PIPE_DEPTH = gcf_pkg::PIPE_DEPTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_wr_en,
  input  wire  [1:0]                           cfg_wr_data,
  input  wire                                  start,
  output logic                                 busy,
  input  wire                                  in_req_type,
  input  wire  [11:0]                          in_port_offset,
  input  wire  [31:0]                          in_cmd_data,
  output logic                                 out_strobe,
  output logic                                 out_entry_valid,
  output logic [6:0]                           out_entry_command,
  output logic [31:0]                          out_entry_param,
  output logic [$clog2(FIFO_DEPTH+1)-1:0]      out_fifo_level,
  output logic [$clog2(PIPE_DEPTH+1)-1:0]      out_pipe_level,
  output logic                                 out_below_half,
  output logic                                 out_fifo_empty,
  output logic                                 out_irq_pulse,
  output logic [1:0]                           out_error_code
);
  import gcf_pkg::*;

  localparam int PTR_W  = $clog2(FIFO_DEPTH);
  localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int PCNT_W = $clog2(PIPE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MOVE1 = 2'd1;
  localparam logic [1:0] ST_MOVE2 = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [PTR_W-1:0]  fifo_head_r, fifo_head_nxt;
  logic [PTR_W-1:0]  fifo_tail_r, fifo_tail_nxt;
  logic [CNT_W-1:0]  fifo_count_r, fifo_count_nxt;
  logic [1:0]        irq_mode_r;

  logic              accept;
  decode_t           dec;
  entry_t            new_entry;
  entry_t            mem_rd_data;
  logic              mem_we;
  pipe_ctl_t         pipe_ctl;
  entry_t            push_entry;
  entry_t            pipe_front;
  logic [PCNT_W-1:0] pipe_count;
  logic [PCNT_W-1:0] pipe_count_after;
  logic              emit;
  logic              irq_check;
  logic [1:0]        err;
  logic              deq_ok;
  logic              below_half_nxt;
  logic              fifo_empty_nxt;

  logic                 out_strobe_r;
  logic                 out_entry_valid_r;
  logic [CMD_W-1:0]     out_entry_command_r;
  logic [DATA_W-1:0]    out_entry_param_r;
  logic [CNT_W-1:0]     out_fifo_level_r;
  logic [PCNT_W-1:0]    out_pipe_level_r;
  logic                 out_below_half_r;
  logic                 out_fifo_empty_r;
  logic                 out_irq_pulse_r;
  logic [1:0]           out_error_code_r;

  // Circular pointer step.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign dec       = gcf_decode(in_port_offset);
  assign new_entry = '{cmd: dec.cmd, data: in_cmd_data};

  // Main FIFO memory; the read address follows the next head so data is ready for a move.
  gcf_fifo_mem #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (fifo_tail_r),
    .wr_data (new_entry),
    .rd_addr (fifo_head_nxt),
    .rd_data (mem_rd_data)
  );

  gcf_pipe #(
    .PIPE_DEPTH(PIPE_DEPTH)
  ) u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (pipe_ctl),
    .push_entry (push_entry),
    .front      (pipe_front),
    .count      (pipe_count)
  );

  // Sequencer: executes the request and moves up to two FIFO entries into the pipe.
  always_comb begin
    state_nxt        = state_r;
    fifo_head_nxt    = fifo_head_r;
    fifo_tail_nxt    = fifo_tail_r;
    fifo_count_nxt   = fifo_count_r;
    mem_we           = 1'b0;
    pipe_ctl         = '0;
    push_entry       = new_entry;
    pipe_count_after = pipe_count;
    emit             = 1'b0;
    irq_check        = 1'b0;
    err              = ERR_NONE;
    deq_ok           = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_WRITE) begin
            emit = 1'b1;
            if (!dec.hit) begin
              err = ERR_UNKNOWN;
            end else if ((fifo_count_r == '0) && (pipe_count < PCNT_W'(PIPE_DEPTH))) begin
              pipe_ctl.push    = 1'b1;
              pipe_count_after = pipe_count + PCNT_W'(1);
            end else if (fifo_count_r == CNT_W'(FIFO_DEPTH)) begin
              err = ERR_FIFO_FULL;
            end else begin
              mem_we         = 1'b1;
              fifo_tail_nxt  = ptr_inc(fifo_tail_r);
              fifo_count_nxt = fifo_count_r + CNT_W'(1);
            end
          end else if (pipe_count == '0) begin
            emit = 1'b1;
            err  = ERR_PIPE_EMPTY;
          end else begin
            deq_ok           = 1'b1;
            pipe_ctl.pop     = 1'b1;
            pipe_count_after = pipe_count - PCNT_W'(1);
            if (pipe_count_after < PCNT_W'(REFILL_BELOW)) begin
              if (fifo_count_r != '0) begin
                state_nxt = ST_MOVE1;
              end else begin
                emit      = 1'b1;
                irq_check = 1'b1;
              end
            end else begin
              emit = 1'b1;
            end
          end
        end
      end
      ST_MOVE1: begin
        pipe_ctl.push    = 1'b1;
        push_entry       = mem_rd_data;
        pipe_count_after = pipe_count + PCNT_W'(1);
        fifo_head_nxt    = ptr_inc(fifo_head_r);
        fifo_count_nxt   = fifo_count_r - CNT_W'(1);
        if ((fifo_count_nxt != '0) && (pipe_count_after < PCNT_W'(PIPE_DEPTH))) begin
          state_nxt = ST_MOVE2;
        end else begin
          state_nxt = ST_IDLE;
          emit      = 1'b1;
          irq_check = 1'b1;
        end
      end
      ST_MOVE2: begin
        pipe_ctl.push    = 1'b1;
        push_entry       = mem_rd_data;
        pipe_count_after = pipe_count + PCNT_W'(1);
        fifo_head_nxt    = ptr_inc(fifo_head_r);
        fifo_count_nxt   = fifo_count_r - CNT_W'(1);
        state_nxt        = ST_IDLE;
        emit             = 1'b1;
        irq_check        = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fifo_head_r  <= '0;
      fifo_tail_r  <= '0;
      fifo_count_r <= '0;
      irq_mode_r   <= IRQ_NEVER;
    end else begin
      state_r      <= state_nxt;
      fifo_head_r  <= fifo_head_nxt;
      fifo_tail_r  <= fifo_tail_nxt;
      fifo_count_r <= fifo_count_nxt;
      if (cfg_wr_en) begin
        irq_mode_r <= cfg_wr_data;
      end
    end
  end

  assign below_half_nxt = (fifo_count_nxt < CNT_W'(FIFO_DEPTH / 2));
  assign fifo_empty_nxt = (fifo_count_nxt == '0);

  // Result beat strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= emit;
    end
  end

  // Dequeued entry is captured when the request is taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_entry_valid_r   <= deq_ok;
      out_entry_command_r <= deq_ok ? pipe_front.cmd  : '0;
      out_entry_param_r   <= deq_ok ? pipe_front.data : '0;
    end
  end

  // Levels, flags and interrupt as they stand after the request.
  always_ff @(posedge clk) begin
    if (emit) begin
      out_fifo_level_r <= fifo_count_nxt;
      out_pipe_level_r <= pipe_count_after;
      out_below_half_r <= below_half_nxt;
      out_fifo_empty_r <= fifo_empty_nxt;
      out_irq_pulse_r  <= irq_check &&
                          (((irq_mode_r == IRQ_BELOW_HALF) && below_half_nxt) ||
                           ((irq_mode_r == IRQ_EMPTY) && fifo_empty_nxt));
      out_error_code_r <= err;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_entry_valid   = out_entry_valid_r;
  assign out_entry_command = out_entry_command_r;
  assign out_entry_param   = out_entry_param_r;
  assign out_fifo_level    = out_fifo_level_r;
  assign out_pipe_level    = out_pipe_level_r;
  assign out_below_half    = out_below_half_r;
  assign out_fifo_empty    = out_fifo_empty_r;
  assign out_irq_pulse     = out_irq_pulse_r;
  assign out_error_code    = out_error_code_r;

`ifndef NO_ASSERTIONS
  // The FIFO never holds more than its depth.
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_count_r <= CNT_W'(FIFO_DEPTH))
    else $error("fifo count exceeds depth");

  // The pipe never holds more than its depth.
  a_pipe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_count <= PCNT_W'(PIPE_DEPTH))
    else $error("pipe count exceeds depth");

  // A move from the FIFO only happens while it holds an entry.
  a_move_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOVE1 || state_r == ST_MOVE2) |-> (fifo_count_r != '0))
    else $error("refill from empty fifo");

  // A write request finishes without leaving the idle state and yields its result beat next.
  a_write_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type == REQ_WRITE)) |=> (out_strobe && !busy))
    else $error("write result beat missing");
`endif

endmodule

`default_nettype wire
